[rtl/hermite_drift_resampler_core_defines.svh]
// Assertion macros shared by the resampler RTL.
// Every assertion is clocked on clock and is disabled while reset is high.
`ifndef HERMITE_DRIFT_RESAMPLER_CORE_DEFINES_SVH
`define HERMITE_DRIFT_RESAMPLER_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define HDR_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
   else $error(msg);
`define HDR_ASSERT_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) \
   else $error(msg);
`else
`define HDR_ASSERT_IMPL(lbl, ante, cons, msg)
`define HDR_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

[rtl/hdr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package hdr_pkg;

   // Most results one input word may cause.
   localparam int unsigned MAX_BURST = 9;

   // Configuration register indexes.
   localparam logic [2:0] CSR_BASE_STEP    = 3'd0;
   localparam logic [2:0] CSR_TARGET_FILL  = 3'd1;
   localparam logic [2:0] CSR_ERROR_LIMIT  = 3'd2;
   localparam logic [2:0] CSR_LOOP_GAIN    = 3'd3;
   localparam logic [2:0] CSR_ADJUST_LIMIT = 3'd4;

   // Configuration reset values.
   localparam logic [31:0] BASE_STEP_RST    = 32'd268435456;
   localparam logic [15:0] TARGET_FILL_RST  = 16'd1920;
   localparam logic [15:0] ERROR_LIMIT_RST  = 16'd4800;
   localparam logic [23:0] LOOP_GAIN_RST    = 24'd26844;
   localparam logic [27:0] ADJUST_LIMIT_RST = 28'd5368709;

   // History taps fetched for one interpolation.
   localparam logic [1:0] RD_KM1 = 2'd0;
   localparam logic [1:0] RD_K   = 2'd1;
   localparam logic [1:0] RD_KP1 = 2'd2;
   localparam logic [1:0] RD_KP2 = 2'd3;

   // Horner steps of the cubic.
   localparam logic [1:0] HS_D2   = 2'd0;
   localparam logic [1:0] HS_D1   = 2'd1;
   localparam logic [1:0] HS_ZERO = 2'd2;

   typedef enum logic [4:0] {
      S_IDLE,
      S_ERR,
      S_GAIN,
      S_TRIM,
      S_STEP,
      S_CHECK,
      S_RD0,
      S_RD1,
      S_RD2,
      S_RD3,
      S_RDW,
      S_COEF,
      S_MUL,
      S_ACC,
      S_FIN,
      S_ADV,
      S_SLOT,
      S_SEND
   } hdr_state_type;

   typedef struct packed {
      logic       take;
      logic       err_en;
      logic       gain_en;
      logic       trim_en;
      logic       step_en;
      logic       rd_en;
      logic [1:0] rd_sel;
      logic       coef_en;
      logic       mul_en;
      logic       acc_en;
      logic [1:0] hstep;
      logic       lane;
      logic       fin_en;
      logic       adv_en;
      logic       send;
      logic       last;
   } hdr_cmd_type;

   typedef struct packed {
      logic behind;
      logic slot_ok;
      logic rsp_free;
   } hdr_status_type;

endpackage
`default_nettype wire

[rtl/hdr_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "hermite_drift_resampler_core_defines.svh"
module hdr_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire hdr_pkg::hdr_status_type status,
   output hdr_pkg::hdr_cmd_type         cmd
);
   import hdr_pkg::*;

   hdr_state_type state_ff, state_in;
   logic [3:0]    n_ff;
   logic          lane_ff;
   logic [1:0]    hstep_ff;
   logic          pend_ff;
   logic          cont_ff;
   logic          cont_c;

   // Another result is due while the read point trails and the burst has room.
   assign cont_c = status.behind && (n_ff < 4'(MAX_BURST));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (req_valid) state_in = S_ERR;
         S_ERR:   state_in = S_GAIN;
         S_GAIN:  state_in = S_TRIM;
         S_TRIM:  state_in = S_STEP;
         S_STEP:  state_in = S_CHECK;
         S_CHECK: begin
            if (pend_ff) state_in = S_SEND;
            else if (cont_c) state_in = S_RD0;
            else state_in = S_IDLE;
         end
         S_RD0:   state_in = S_RD1;
         S_RD1:   state_in = S_RD2;
         S_RD2:   state_in = S_RD3;
         S_RD3:   state_in = S_RDW;
         S_RDW:   state_in = S_COEF;
         S_COEF:  state_in = S_MUL;
         S_MUL:   state_in = S_ACC;
         S_ACC: begin
            if ((hstep_ff == HS_ZERO) && lane_ff) state_in = S_FIN;
            else state_in = S_MUL;
         end
         S_FIN:   state_in = S_ADV;
         S_ADV:   state_in = S_SLOT;
         S_SLOT:  if (status.slot_ok) state_in = S_CHECK;
         S_SEND: begin
            if (status.rsp_free) state_in = cont_ff ? S_RD0 : S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      cmd        = '0;
      req_ready  = 1'b0;
      cmd.lane   = lane_ff;
      cmd.hstep  = hstep_ff;
      cmd.last   = !cont_ff;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.take  = req_valid;
         end
         S_ERR:   cmd.err_en = 1'b1;
         S_GAIN:  cmd.gain_en = 1'b1;
         S_TRIM:  cmd.trim_en = 1'b1;
         S_STEP:  cmd.step_en = 1'b1;
         S_RD0: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_KM1;
         end
         S_RD1: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_K;
         end
         S_RD2: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_KP1;
         end
         S_RD3: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_KP2;
         end
         S_COEF:  cmd.coef_en = 1'b1;
         S_MUL:   cmd.mul_en = 1'b1;
         S_ACC:   cmd.acc_en = 1'b1;
         S_FIN:   cmd.fin_en = 1'b1;
         S_ADV:   cmd.adv_en = 1'b1;
         S_SEND:  cmd.send = status.rsp_free;
         default: ;
      endcase
   end

   // State, burst count and Horner position.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         n_ff     <= '0;
         lane_ff  <= 1'b0;
         hstep_ff <= HS_D2;
         pend_ff  <= 1'b0;
         cont_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_IDLE) n_ff <= '0;
         if (state_ff == S_CHECK) cont_ff <= cont_c;
         if (state_ff == S_COEF) begin
            lane_ff  <= 1'b0;
            hstep_ff <= HS_D2;
         end
         if (state_ff == S_ACC) begin
            if (hstep_ff == HS_ZERO) begin
               hstep_ff <= HS_D2;
               lane_ff  <= 1'b1;
            end else begin
               hstep_ff <= hstep_ff + 2'd1;
            end
         end
         if (state_ff == S_FIN) begin
            pend_ff <= 1'b1;
            n_ff    <= n_ff + 4'd1;
         end
         if ((state_ff == S_SEND) && status.rsp_free) pend_ff <= 1'b0;
      end
   end

   `HDR_ASSERT_NEVER(burst_cap_held, n_ff > 4'(MAX_BURST), "burst count passed its cap")
   `HDR_ASSERT_NEVER(no_stranded_result, (state_ff == S_IDLE) && pend_ff,
      "idle with an unsent result")
   `HDR_ASSERT_IMPL(send_after_check, state_ff == S_SEND, $past(state_ff) == S_CHECK
      || $past(state_ff) == S_SEND, "send state entered out of order")

endmodule
`default_nettype wire

[rtl/hdr_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "hermite_drift_resampler_core_defines.svh"
module hdr_datapath #(
   parameter int HISTORY_DEPTH = 8,
   parameter int SAMPLE_BITS   = 24,
   parameter int PHASE_BITS    = 28
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_we,
   input  wire logic [2:0]                    csr_addr,
   input  wire logic [31:0]                   csr_wdata,
   input  wire logic signed [SAMPLE_BITS-1:0] req_left_in,
   input  wire logic signed [SAMPLE_BITS-1:0] req_right_in,
   input  wire logic [15:0]                   req_fill_level,
   input  wire logic                          rsp_ready,
   output logic                               rsp_valid,
   output logic signed [SAMPLE_BITS-1:0]      rsp_left_sample,
   output logic signed [SAMPLE_BITS-1:0]      rsp_right_sample,
   output logic                               rsp_last_of_burst,
   input  wire hdr_pkg::hdr_cmd_type          cmd,
   output hdr_pkg::hdr_status_type            status
);
   import hdr_pkg::*;

   localparam int SLW = $clog2(HISTORY_DEPTH);
   localparam int ACW = ((SLW > 6) ? SLW : 6) + 1;
   localparam int SW  = PHASE_BITS + 5;
   localparam int AW  = SAMPLE_BITS + 5;
   localparam int MW  = AW - 1 + PHASE_BITS;
   localparam int FW  = 2 * SAMPLE_BITS;
   localparam logic signed [AW-1:0] SMAX = AW'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
   localparam logic signed [AW-1:0] SMIN = -SMAX - AW'(1);
   localparam logic [SLW-1:0] SLOT_LAST = SLW'(HISTORY_DEPTH - 1);

   // Configuration registers.
   logic [31:0] base_step_ff;
   logic [15:0] target_fill_ff;
   logic [15:0] error_limit_ff;
   logic [23:0] loop_gain_ff;
   logic [27:0] adjust_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_step_ff    <= BASE_STEP_RST;
         target_fill_ff  <= TARGET_FILL_RST;
         error_limit_ff  <= ERROR_LIMIT_RST;
         loop_gain_ff    <= LOOP_GAIN_RST;
         adjust_limit_ff <= ADJUST_LIMIT_RST;
      end else if (csr_we) begin
         priority case (csr_addr)
            CSR_BASE_STEP:    base_step_ff <= csr_wdata;
            CSR_TARGET_FILL:  target_fill_ff <= csr_wdata[15:0];
            CSR_ERROR_LIMIT:  error_limit_ff <= csr_wdata[15:0];
            CSR_LOOP_GAIN:    loop_gain_ff <= csr_wdata[23:0];
            CSR_ADJUST_LIMIT: adjust_limit_ff <= csr_wdata[27:0];
            default: ;
         endcase
      end
   end

   // Write side: frame counter and its ring slot.
   logic [31:0]    fw_ff;
   logic [SLW-1:0] wr_slot_ff;
   logic [15:0]    fill_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff      <= '0;
         wr_slot_ff <= '0;
      end else if (cmd.take) begin
         fw_ff <= fw_ff + 32'd1;
         if ((fw_ff == '1) || (wr_slot_ff == SLOT_LAST)) wr_slot_ff <= '0;
         else wr_slot_ff <= wr_slot_ff + SLW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) fill_ff <= req_fill_level;
   end

   // Read position; the slot register is reduced below the depth one subtract a cycle.
   logic [31:0]           whole_ff;
   logic [PHASE_BITS-1:0] phase_ff;
   logic [ACW-1:0]        slot_ff;
   logic [SW-1:0]         step_ff;
   logic [SW:0]           total_c;
   logic [SW-PHASE_BITS:0] adv_c;
   logic [32:0]           whole_sum_c;

   assign total_c     = (SW + 1)'(phase_ff) + (SW + 1)'(step_ff);
   assign adv_c       = total_c[SW:PHASE_BITS];
   assign whole_sum_c = 33'(whole_ff) + 33'(adv_c);

   always_ff @(posedge clock) begin
      if (reset) begin
         whole_ff <= '0;
         phase_ff <= '0;
         slot_ff  <= '0;
      end else if (cmd.adv_en) begin
         whole_ff <= whole_sum_c[31:0];
         phase_ff <= total_c[PHASE_BITS-1:0];
         if (whole_sum_c[32]) slot_ff <= ACW'(whole_sum_c[5:0]);
         else slot_ff <= slot_ff + ACW'(adv_c);
      end else if (slot_ff >= ACW'(HISTORY_DEPTH)) begin
         slot_ff <= slot_ff - ACW'(HISTORY_DEPTH);
      end
   end

   // Fill error, clamped, then its magnitude.
   logic signed [16:0] err_c;
   logic [16:0]        err_abs_c;
   logic [15:0]        mag_ff;
   logic               neg_ff;
   logic [39:0]        gprod_ff;
   logic [35:0]        tm_c;
   logic [27:0]        tmag_c;
   logic [31:0]        trim_ff;
   logic [32:0]        step33_c;

   assign err_c     = $signed({1'b0, fill_ff}) - $signed({1'b0, target_fill_ff});
   assign err_abs_c = err_c[16] ? 17'(-err_c) : 17'(err_c);
   assign tm_c      = gprod_ff[39:4];
   assign tmag_c    = (tm_c > 36'(adjust_limit_ff)) ? adjust_limit_ff : tm_c[27:0];
   assign step33_c  = neg_ff ? ({1'b0, base_step_ff} - {1'b0, trim_ff})
                             : ({1'b0, base_step_ff} + {1'b0, trim_ff});

   always_ff @(posedge clock) begin
      if (cmd.err_en) begin
         neg_ff <= err_c[16];
         mag_ff <= (err_abs_c > 17'(error_limit_ff)) ? error_limit_ff : err_abs_c[15:0];
      end
      if (cmd.gain_en) gprod_ff <= 40'(mag_ff) * 40'(loop_gain_ff);
      if (cmd.trim_en) trim_ff <= 32'((60'(base_step_ff) * 60'(tmag_c)) >> 28);
   end

   // Step rescaled from 28 fraction bits to the phase width.
   generate
      if (PHASE_BITS >= 28) begin : g_step_up
         always_ff @(posedge clock) begin
            if (cmd.step_en) step_ff <= SW'(step33_c) << (PHASE_BITS - 28);
         end
      end else begin : g_step_down
         always_ff @(posedge clock) begin
            if (cmd.step_en) step_ff <= SW'(step33_c >> (28 - PHASE_BITS));
         end
      end
   endgenerate

   // History taps around the read point, with the counter wrap and frame zero cases.
   logic [SLW-1:0] k_c, km1_c, kp1_c, kp2_c, inc1_c, inc2_c, rd_addr_c;
   logic [31:0]    dist_c;

   assign k_c    = slot_ff[SLW-1:0];
   assign inc1_c = (k_c == SLOT_LAST) ? '0 : k_c + SLW'(1);
   assign inc2_c = (inc1_c == SLOT_LAST) ? '0 : inc1_c + SLW'(1);
   assign km1_c  = (whole_ff == '0) ? k_c : ((k_c == '0) ? SLOT_LAST : k_c - SLW'(1));
   assign kp1_c  = (whole_ff == '1) ? '0 : inc1_c;
   assign kp2_c  = (whole_ff == '1) ? SLW'(1)
                 : ((whole_ff == 32'hFFFF_FFFE) ? '0 : inc2_c);

   always_comb begin
      unique case (cmd.rd_sel)
         RD_KM1:  rd_addr_c = km1_c;
         RD_K:    rd_addr_c = k_c;
         RD_KP1:  rd_addr_c = kp1_c;
         RD_KP2:  rd_addr_c = kp2_c;
         default: rd_addr_c = k_c;
      endcase
   end

   assign dist_c         = fw_ff - whole_ff;
   assign status.behind  = (dist_c > 32'd4) && !dist_c[31];
   assign status.slot_ok = slot_ff < ACW'(HISTORY_DEPTH);

   // Frame history memory; an entry never written reads as zero.
   logic [FW-1:0]            mem [HISTORY_DEPTH];
   logic [HISTORY_DEPTH-1:0] valid_ff;
   logic [FW-1:0]            q_ff;
   logic                     qv_ff;

   always_ff @(posedge clock) begin
      if (cmd.take) mem[wr_slot_ff] <= {req_left_in, req_right_in};
      if (cmd.rd_en) begin
         q_ff  <= mem[rd_addr_c];
         qv_ff <= valid_ff[rd_addr_c];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else if (cmd.take) valid_ff[wr_slot_ff] <= 1'b1;
   end

   // Tap capture from the registered read word.
   logic                          rd_pend_ff;
   logic [1:0]                    rd_sel_q_ff;
   logic signed [SAMPLE_BITS-1:0] y_ff [2][4];

   always_ff @(posedge clock) begin
      if (reset) rd_pend_ff <= 1'b0;
      else rd_pend_ff <= cmd.rd_en;
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) rd_sel_q_ff <= cmd.rd_sel;
      if (rd_pend_ff) begin
         y_ff[0][rd_sel_q_ff] <= qv_ff ? q_ff[FW-1:SAMPLE_BITS] : '0;
         y_ff[1][rd_sel_q_ff] <= qv_ff ? q_ff[SAMPLE_BITS-1:0] : '0;
      end
   end

   // Catmull-Rom coefficients and Horner evaluation on one shared multiplier.
   logic signed [AW-1:0] a_ff  [2];
   logic signed [AW-1:0] d1_ff [2];
   logic signed [AW-1:0] d2_ff [2];
   logic signed [AW-1:0] sel_a_c, mabs_c, sv_c, addend_c;
   logic [MW-1:0]        prod_ff;
   logic                 pneg_ff;
   logic [AW-2:0]        psh_c;

   assign sel_a_c = a_ff[cmd.lane];
   assign mabs_c  = sel_a_c[AW-1] ? -sel_a_c : sel_a_c;
   assign psh_c   = prod_ff[MW-1:PHASE_BITS];
   assign sv_c    = pneg_ff ? -$signed({1'b0, psh_c}) : $signed({1'b0, psh_c});

   always_comb begin
      unique case (cmd.hstep)
         HS_D2:   addend_c = d2_ff[cmd.lane];
         HS_D1:   addend_c = d1_ff[cmd.lane];
         default: addend_c = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.coef_en) begin
         for (int c = 0; c < 2; c++) begin
            d1_ff[c] <= AW'(y_ff[c][2]) - AW'(y_ff[c][0]);
            d2_ff[c] <= AW'(2) * AW'(y_ff[c][0]) - AW'(5) * AW'(y_ff[c][1])
                      + AW'(4) * AW'(y_ff[c][2]) - AW'(y_ff[c][3]);
            a_ff[c]  <= AW'(y_ff[c][3]) - AW'(y_ff[c][0])
                      + AW'(3) * (AW'(y_ff[c][1]) - AW'(y_ff[c][2]));
         end
      end
      if (cmd.mul_en) begin
         prod_ff <= MW'(mabs_c[AW-2:0]) * MW'(phase_ff);
         pneg_ff <= sel_a_c[AW-1];
      end
      if (cmd.acc_en) a_ff[cmd.lane] <= sv_c + addend_c;
   end

   // Final halving, add of the centre tap and saturation.
   logic signed [AW-1:0]          half_c [2];
   logic signed [AW-1:0]          sum_c  [2];
   logic signed [SAMPLE_BITS-1:0] sat_c  [2];
   logic signed [SAMPLE_BITS-1:0] res_ff [2];

   always_comb begin
      for (int c = 0; c < 2; c++) begin
         half_c[c] = $signed(a_ff[c] + AW'(a_ff[c][AW-1])) >>> 1;
         sum_c[c]  = AW'(y_ff[c][1]) + half_c[c];
         if (sum_c[c] > SMAX) sat_c[c] = SMAX[SAMPLE_BITS-1:0];
         else if (sum_c[c] < SMIN) sat_c[c] = SMIN[SAMPLE_BITS-1:0];
         else sat_c[c] = sum_c[c][SAMPLE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fin_en) begin
         res_ff[0] <= sat_c[0];
         res_ff[1] <= sat_c[1];
      end
   end

   // Output register.
   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.send) rsp_valid_ff <= 1'b1;
      else if (rsp_ready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.send) begin
         rsp_left_sample   <= res_ff[0];
         rsp_right_sample  <= res_ff[1];
         rsp_last_of_burst <= cmd.last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign status.rsp_free = !rsp_valid_ff || rsp_ready;

   `HDR_ASSERT_IMPL(send_into_free_slot, cmd.send, !rsp_valid_ff || rsp_ready,
      "result loaded over an untaken word")
   `HDR_ASSERT_IMPL(read_slot_reduced, cmd.rd_en, status.slot_ok,
      "history read with an unreduced slot")

endmodule
`default_nettype wire

[rtl/hermite_drift_resampler_core.sv]
// From an accepted word the sequencer works out the fill error, gain, trim and step, then
// interpolates each result (4 history reads, 6 multiply/accumulate steps on one multiplier).
// A word causes 0 to 9 results; the next word is taken only once the block is idle again.
// The slot reduction after a large step can hold a result back in the slot state.
// Reset (synchronous, active high) clears counters, phase and history valid bits and
// loads the register defaults; history then reads as zero until written.
`timescale 1ns / 1ps
`default_nettype none
module hermite_drift_resampler_core #(
   parameter int HISTORY_DEPTH = 8,
   parameter int SAMPLE_BITS   = 24,
   parameter int PHASE_BITS    = 28
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_we,
   input  wire logic [2:0]                    csr_addr,
   input  wire logic [31:0]                   csr_wdata,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic signed [SAMPLE_BITS-1:0] req_left_in,
   input  wire logic signed [SAMPLE_BITS-1:0] req_right_in,
   input  wire logic [15:0]                   req_fill_level,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]      rsp_left_sample,
   output logic signed [SAMPLE_BITS-1:0]      rsp_right_sample,
   output logic                               rsp_last_of_burst
);
   import hdr_pkg::*;

   hdr_cmd_type    cmd;
   hdr_status_type status;

   // Sequencer.
   hdr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Arithmetic, history and output register.
   hdr_datapath #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .SAMPLE_BITS   (SAMPLE_BITS),
      .PHASE_BITS    (PHASE_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_addr          (csr_addr),
      .csr_wdata         (csr_wdata),
      .req_left_in       (req_left_in),
      .req_right_in      (req_right_in),
      .req_fill_level    (req_fill_level),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_left_sample   (rsp_left_sample),
      .rsp_right_sample  (rsp_right_sample),
      .rsp_last_of_burst (rsp_last_of_burst),
      .cmd               (cmd),
      .status            (status)
   );

endmodule
`default_nettype wire

[test/tb_hermite_drift_resampler_core.sv]
`timescale 1ns / 1ps
module tb_hermite_drift_resampler_core;
   import hdr_pkg::*;

   typedef struct {
      logic signed [23:0] left;
      logic signed [23:0] right;
      logic [15:0]        fill;
   } frame_word_type;

   typedef struct {
      logic signed [23:0] left;
      logic signed [23:0] right;
      logic               last;
   } sample_word_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_we = 1'b0;
   logic [2:0]         csr_addr = '0;
   logic [31:0]        csr_wdata = '0;
   logic               req_valid = 1'b0;
   wire                req_ready;
   logic signed [23:0] req_left_in = '0;
   logic signed [23:0] req_right_in = '0;
   logic [15:0]        req_fill_level = '0;
   wire                rsp_valid;
   logic               rsp_ready = 1'b0;
   wire signed [23:0]  rsp_left_sample;
   wire signed [23:0]  rsp_right_sample;
   wire                rsp_last_of_burst;

   frame_word_type  frame_q[$];
   sample_word_type sample_q[$];
   int              error_count = 0;
   logic            quiet = 1'b0;

   // Shadow of the block's history, read position and registers.
   logic signed [23:0] hist_l[8];
   logic signed [23:0] hist_r[8];
   logic [31:0] written_cnt = '0;
   logic [31:0] rd_whole = '0;
   logic [27:0] rd_phase = '0;
   logic [31:0] cfg_base = BASE_STEP_RST;
   logic [15:0] cfg_target = TARGET_FILL_RST;
   logic [15:0] cfg_err_lim = ERROR_LIMIT_RST;
   logic [23:0] cfg_gain = LOOP_GAIN_RST;
   logic [27:0] cfg_adj_lim = ADJUST_LIMIT_RST;

   hermite_drift_resampler_core u_dut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_left_in(req_left_in), .req_right_in(req_right_in),
      .req_fill_level(req_fill_level),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_left_sample(rsp_left_sample), .rsp_right_sample(rsp_right_sample),
      .rsp_last_of_burst(rsp_last_of_burst)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Product with the phase, scaled back and truncated toward zero.
   function automatic longint phase_mul(longint a, logic [27:0] t);
      logic [63:0] m;
      logic [95:0] p;
      m = (a < 0) ? -a : a;
      p = {32'b0, m} * {68'b0, t};
      p = p >> 28;
      return (a < 0) ? -longint'(p[63:0]) : longint'(p[63:0]);
   endfunction

   function automatic logic signed [23:0] catmull(logic [27:0] t, longint y0, longint y1,
                                                  longint y2, longint y3);
      longint acc;
      longint v;
      acc = y3 - y0 + 3 * (y1 - y2);
      acc = phase_mul(acc, t) + (2 * y0 - 5 * y1 + 4 * y2 - y3);
      acc = phase_mul(acc, t) + (y2 - y0);
      acc = phase_mul(acc, t);
      v = y1 + ((acc < 0) ? -((-acc) >>> 1) : (acc >>> 1));
      if (v > 8388607) v = 8388607;
      if (v < -8388608) v = -8388608;
      return v[23:0];
   endfunction

   // Store one frame, derive the trimmed step and queue the samples it releases.
   task automatic resample_frame(frame_word_type w);
      longint      err;
      logic [63:0] mag;
      logic [63:0] trim;
      logic [63:0] step;
      logic [63:0] total;
      logic [31:0] d;
      logic [31:0] km1;
      int          n;
      sample_word_type s;
      hist_l[written_cnt[2:0]] = w.left;
      hist_r[written_cnt[2:0]] = w.right;
      written_cnt = written_cnt + 1;
      err = longint'(w.fill) - longint'(cfg_target);
      if (err > longint'(cfg_err_lim)) err = longint'(cfg_err_lim);
      if (err < -longint'(cfg_err_lim)) err = -longint'(cfg_err_lim);
      mag = (err < 0) ? -err : err;
      mag = (mag * cfg_gain) >> 4;
      if (mag > cfg_adj_lim) mag = cfg_adj_lim;
      trim = ({32'b0, cfg_base} * mag) >> 28;
      step = (err < 0) ? cfg_base - trim : cfg_base + trim;
      n = 0;
      while (n < MAX_BURST) begin
         d = written_cnt - rd_whole;
         if (d <= 4 || d >= 32'h8000_0000) break;
         km1 = (rd_whole == 0) ? 32'd0 : rd_whole - 1;
         s.left = catmull(rd_phase, hist_l[km1[2:0]], hist_l[rd_whole[2:0]],
                          hist_l[3'(rd_whole + 1)], hist_l[3'(rd_whole + 2)]);
         s.right = catmull(rd_phase, hist_r[km1[2:0]], hist_r[rd_whole[2:0]],
                           hist_r[3'(rd_whole + 1)], hist_r[3'(rd_whole + 2)]);
         s.last = 1'b0;
         sample_q.push_back(s);
         n++;
         total = rd_phase + step;
         rd_whole = rd_whole + total[59:28];
         rd_phase = total[27:0];
      end
      if (n > 0) sample_q[$].last = 1'b1;
   endtask

   task automatic report(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Driver: on a free channel, present the next queued word, with random gaps unless quiet.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= quiet || ($urandom_range(99) >= 10);
         if (!req_valid || req_ready) begin
            if (req_valid) begin
               resample_frame('{req_left_in, req_right_in, req_fill_level});
            end
            if (frame_q.size() > 0 && (quiet || $urandom_range(99) >= 10)) begin
               req_valid <= 1'b1;
               req_left_in <= frame_q[0].left;
               req_right_in <= frame_q[0].right;
               req_fill_level <= frame_q[0].fill;
               frame_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: every accepted word is checked against the oldest expected sample.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (sample_q.size() == 0) begin
            report("unexpected word", rsp_left_sample, 0);
         end else begin
            if (rsp_left_sample !== sample_q[0].left)
               report("left sample", rsp_left_sample, sample_q[0].left);
            if (rsp_right_sample !== sample_q[0].right)
               report("right sample", rsp_right_sample, sample_q[0].right);
            if (rsp_last_of_burst !== sample_q[0].last)
               report("last_of_burst", rsp_last_of_burst, sample_q[0].last);
            sample_q.pop_front();
         end
      end
   end

   task automatic wait_idle();
      while (frame_q.size() > 0 || req_valid || sample_q.size() > 0) @(posedge clock);
      repeat (600) @(posedge clock);
   endtask

   // Registers are only written while the block is idle.
   task automatic csr_write(logic [2:0] idx, logic [31:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_BASE_STEP:    cfg_base = val;
         CSR_TARGET_FILL:  cfg_target = val[15:0];
         CSR_ERROR_LIMIT:  cfg_err_lim = val[15:0];
         CSR_LOOP_GAIN:    cfg_gain = val[23:0];
         CSR_ADJUST_LIMIT: cfg_adj_lim = val[27:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic push_random(int count);
      frame_word_type w;
      repeat (count) begin
         w.left = 24'($urandom());
         w.right = 24'($urandom());
         case ($urandom_range(3))
            0: w.fill = 16'($urandom());
            1: w.fill = 16'(cfg_target + $urandom_range(64) - 32);
            2: w.fill = ($urandom_range(1)) ? 16'hFFFF : 16'h0000;
            default: w.fill = 16'($urandom_range(4000));
         endcase
         if ($urandom_range(9) == 0) w.left = 24'sh7FFFFF;
         if ($urandom_range(9) == 0) w.right = -24'sh800000;
         frame_q.push_back(w);
      end
   endtask

   initial begin
      frame_word_type w;
      for (int i = 0; i < 8; i++) begin
         hist_l[i] = '0;
         hist_r[i] = '0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: sample extremes, alternating full scale to force saturation,
      // fill at zero, at the target and at full scale, starting before frame zero.
      for (int i = 0; i < 20; i++) begin
         w.left = (i % 2) ? 24'sh7FFFFF : -24'sh800000;
         w.right = (i % 3 == 0) ? 24'sh000000 : ((i % 2) ? -24'sh800000 : 24'sh7FFFFF);
         w.fill = (i % 3 == 0) ? 16'd0 : ((i % 3 == 1) ? 16'hFFFF : cfg_target);
         frame_q.push_back(w);
      end
      wait_idle();

      // Slowest legal step with the widest trim clamps.
      csr_write(CSR_BASE_STEP, 32'd33554432);
      csr_write(CSR_ERROR_LIMIT, 32'hFFFF_FFFF);
      csr_write(CSR_LOOP_GAIN, 32'hFFFF_FFFF);
      csr_write(CSR_ADJUST_LIMIT, 32'hFFFF_FFFF);
      csr_write(CSR_TARGET_FILL, 32'h0000_8000);
      push_random(25);
      wait_idle();

      // Fastest step: reads run ahead of the history and most frames release nothing.
      csr_write(CSR_BASE_STEP, 32'hFFFF_FFFF);
      csr_write(CSR_TARGET_FILL, 32'd0);
      csr_write(CSR_ERROR_LIMIT, 32'd0);
      csr_write(CSR_LOOP_GAIN, 32'd0);
      csr_write(CSR_ADJUST_LIMIT, 32'd0);
      push_random(20);
      wait_idle();

      // A step below the legal range hits the burst cap; unknown indexes are ignored.
      csr_write(CSR_BASE_STEP, 32'd1000000);
      csr_write(3'd5, $urandom());
      csr_write(3'd7, $urandom());
      push_random(10);
      wait_idle();

      // Near-unity ratio with random loop settings and no idling at all.
      quiet = 1'b1;
      csr_write(CSR_BASE_STEP, 32'h1000_0000 + $urandom_range(32'h0100_0000));
      csr_write(CSR_TARGET_FILL, $urandom_range(3000));
      csr_write(CSR_ERROR_LIMIT, $urandom_range(6000));
      csr_write(CSR_LOOP_GAIN, $urandom_range(100000));
      csr_write(CSR_ADJUST_LIMIT, $urandom_range(32'h0200_0000));
      push_random(30);
      wait_idle();
      quiet = 1'b0;

      // Back to defaults-like rates with random idling.
      csr_write(CSR_BASE_STEP, $urandom_range(32'h4000_0000, 32'h0800_0000));
      csr_write(CSR_TARGET_FILL, TARGET_FILL_RST);
      csr_write(CSR_ERROR_LIMIT, ERROR_LIMIT_RST);
      csr_write(CSR_LOOP_GAIN, LOOP_GAIN_RST);
      csr_write(CSR_ADJUST_LIMIT, ADJUST_LIMIT_RST);
      push_random(25);
      wait_idle();

      if (error_count == 0) begin
         $display("[hermite_drift_resampler_core] OK");
      end else begin
         $display("[hermite_drift_resampler_core] ERROR");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #8ms;
      $display("[hermite_drift_resampler_core] ERROR");
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl
rtl/hdr_pkg.sv
rtl/hdr_ctrl.sv
rtl/hdr_datapath.sv
rtl/hermite_drift_resampler_core.sv
test/tb_hermite_drift_resampler_core.sv
